// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker in mld_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off while reset is asserted.
`define MLD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, off while reset is asserted.
`define MLD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Implication in the next cycle, checked through reset as well.
`define MLD_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mld_pkg.sv =====
// Types and constants of the marked line demultiplexer.
package mld_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 13;
    localparam int MC_W       = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_COL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_CODE    = 3'd4;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] RST_ROW_WIDTH    = 14'd4096;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 14'd4096;
    localparam logic [MC_W-1:0]       RST_MARKER_COL   = 6'd3;
    localparam logic [PIX_W-1:0]      RST_BRIGHT_CODE  = 8'd64;
    localparam logic [PIX_W-1:0]      RST_DARK_CODE    = 8'd32;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             pixel_valid;
        logic             to_dark;
        logic [ROW_W-1:0] dest_row;
        logic [COL_W-1:0] dest_col;
        logic             row_end;
        logic             frame_done;
        logic             frame_error;
    } t_pix_out;

    typedef enum logic [1:0] {
        ROUTE_UNDECIDED,
        ROUTE_BRIGHT,
        ROUTE_DARK,
        ROUTE_DROP
    } t_route;

    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_REPLAY,
        CMD_STATUS
    } t_cmd_kind;

    // one queue entry: what the back end emits for one accepted pixel
    typedef struct packed {
        t_cmd_kind        kind;
        logic [PIX_W-1:0] pixel;
        logic             to_dark;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             row_end;
        logic             frame_done;
        logic             frame_error;
        logic [MC_W-1:0]  rep_len;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_CMD,
        BK_REPLAY,
        BK_MARK
    } t_back_state;

endpackage

// ===== hw/rtl/mld_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module mld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/mld_front.sv =====
// Front end: configuration registers, line classification, prefix capture.
module mld_front #(
    parameter int MAX_WIDTH    = 8192,
    parameter int MAX_HEIGHT   = 8192,
    parameter int PREFIX_DEPTH = 63
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mld_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mld_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_valid,
    input  mld_pkg::t_pix_in                     i_data,
    output logic                                 o_stall,
    output logic                                 o_push,
    output mld_pkg::t_cmd                        o_cmd,
    input  logic                                 i_full,
    output logic                                 o_ram_we,
    output logic [((PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1)-1:0] o_ram_addr,
    output logic [mld_pkg::PIX_W-1:0]            o_ram_wdata,
    input  logic                                 i_replay_done
);

    localparam int AW  = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = (mld_pkg::CFG_DATA_W > $clog2(MAX_WIDTH + 1)) ?
                         mld_pkg::CFG_DATA_W : $clog2(MAX_WIDTH + 1);
    localparam int HW  = (mld_pkg::CFG_DATA_W > $clog2(MAX_HEIGHT + 1)) ?
                         mld_pkg::CFG_DATA_W : $clog2(MAX_HEIGHT + 1);
    localparam int LW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT / 2 + 1);
    localparam int MCW = mld_pkg::MC_W;

    logic [mld_pkg::CFG_DATA_W-1:0] r_row_width;
    logic [mld_pkg::CFG_DATA_W-1:0] r_frame_height;
    logic [MCW-1:0]                 r_marker_col;
    logic [mld_pkg::PIX_W-1:0]      r_bright_code;
    logic [mld_pkg::PIX_W-1:0]      r_dark_code;

    logic [CW-1:0]    r_col, n_col, w_col;
    logic [LW-1:0]    r_line, n_line, w_line;
    mld_pkg::t_route  r_route, n_route, w_route;
    logic [RW-1:0]    r_bright, n_bright, w_bright;
    logic [RW-1:0]    r_dark, n_dark, w_dark;
    logic             r_err, n_err, w_err;
    logic             r_replay_busy, n_replay_busy;

    logic             w_fire;
    logic             w_fs;
    logic             w_pref_wr;
    logic             w_push;
    logic             w_last;
    logic             w_is_bright;
    logic             w_is_dark;
    logic [WW-1:0]    w_width;
    logic [HW-1:0]    w_height;
    logic [HW-1:0]    w_half;
    logic [MCW-1:0]   w_mc;
    mld_pkg::t_cmd    w_cmd;

    // configuration port is always open; unknown indexes are ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= mld_pkg::RST_ROW_WIDTH;
            r_frame_height <= mld_pkg::RST_FRAME_HEIGHT;
            r_marker_col   <= mld_pkg::RST_MARKER_COL;
            r_bright_code  <= mld_pkg::RST_BRIGHT_CODE;
            r_dark_code    <= mld_pkg::RST_DARK_CODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mld_pkg::CFG_ROW_WIDTH:    r_row_width    <= i_cfg_data;
                mld_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                mld_pkg::CFG_MARKER_COL:   r_marker_col   <= MCW'(i_cfg_data);
                mld_pkg::CFG_BRIGHT_CODE:  r_bright_code  <= mld_pkg::PIX_W'(i_cfg_data);
                mld_pkg::CFG_DARK_CODE:    r_dark_code    <= mld_pkg::PIX_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // saturated configuration
    always_comb begin
        w_width = WW'(r_row_width);
        if (w_width == '0) begin
            w_width = WW'(1);
        end else if (w_width > WW'(MAX_WIDTH)) begin
            w_width = WW'(MAX_WIDTH);
        end
        w_height = HW'(r_frame_height);
        if (w_height < HW'(2)) begin
            w_height = HW'(2);
        end else if (w_height > HW'(MAX_HEIGHT)) begin
            w_height = HW'(MAX_HEIGHT);
        end
        w_half = w_height >> 1;
        w_mc = (r_marker_col > MCW'(PREFIX_DEPTH)) ? MCW'(PREFIX_DEPTH) : r_marker_col;
    end

    // frame_start clears the frame state before the pixel is handled
    assign w_fs     = i_data.frame_start;
    assign w_col    = w_fs ? '0 : r_col;
    assign w_line   = w_fs ? '0 : r_line;
    assign w_route  = w_fs ? mld_pkg::ROUTE_UNDECIDED : r_route;
    assign w_bright = w_fs ? '0 : r_bright;
    assign w_dark   = w_fs ? '0 : r_dark;
    assign w_err    = w_fs ? 1'b0 : r_err;

    assign w_last      = (WW'(w_col) + WW'(1)) >= w_width;
    assign w_is_bright = (i_data.pixel_in == r_bright_code);
    assign w_is_dark   = (i_data.pixel_in == r_dark_code);

    always_comb begin
        n_route   = w_route;
        n_err     = w_err;
        n_bright  = w_bright;
        n_dark    = w_dark;
        n_col     = CW'(w_col + CW'(1));
        n_line    = w_line;
        w_pref_wr = 1'b0;
        w_push    = 1'b0;
        w_cmd     = '0;

        case (w_route)
            mld_pkg::ROUTE_UNDECIDED: begin
                if (WW'(w_col) < WW'(w_mc)) begin
                    w_pref_wr = 1'b1;
                end else if (WW'(w_col) == WW'(w_mc)) begin
                    if (w_is_bright && (HW'(w_bright) < w_half)) begin
                        n_route = mld_pkg::ROUTE_BRIGHT;
                    end else if (w_is_bright) begin
                        n_route = mld_pkg::ROUTE_DROP;
                    end else if (w_is_dark && (HW'(w_dark) < w_half)) begin
                        n_route = mld_pkg::ROUTE_DARK;
                    end else begin
                        n_route = mld_pkg::ROUTE_DROP;
                    end
                end else begin
                    // marker column passed unclassified
                    n_route = mld_pkg::ROUTE_DROP;
                end
            end
            default: ;
        endcase

        if (n_route == mld_pkg::ROUTE_DROP && w_route != mld_pkg::ROUTE_DROP) begin
            n_err = 1'b1;
        end

        if (n_route == mld_pkg::ROUTE_BRIGHT || n_route == mld_pkg::ROUTE_DARK) begin
            w_push        = 1'b1;
            w_cmd.kind    = (w_route == mld_pkg::ROUTE_UNDECIDED && w_mc != '0) ?
                            mld_pkg::CMD_REPLAY : mld_pkg::CMD_PIXEL;
            w_cmd.pixel   = i_data.pixel_in;
            w_cmd.to_dark = (n_route == mld_pkg::ROUTE_DARK);
            w_cmd.row     = (n_route == mld_pkg::ROUTE_DARK) ?
                            mld_pkg::ROW_W'(w_dark) : mld_pkg::ROW_W'(w_bright);
            w_cmd.col     = mld_pkg::COL_W'(w_col);
            w_cmd.row_end = w_last;
            w_cmd.rep_len = w_mc;
        end

        if (w_last) begin
            case (n_route)
                mld_pkg::ROUTE_UNDECIDED: n_err    = 1'b1;
                mld_pkg::ROUTE_BRIGHT:    n_bright = RW'(w_bright + RW'(1));
                mld_pkg::ROUTE_DARK:      n_dark   = RW'(w_dark + RW'(1));
                default: ;
            endcase
            n_route = mld_pkg::ROUTE_UNDECIDED;
            n_col   = '0;
            n_line  = LW'(w_line + LW'(1));
        end

        w_cmd.frame_error = n_err;

        if (w_last && (HW'(n_line) >= w_height)) begin
            if (!w_push) begin
                w_push            = 1'b1;
                w_cmd.kind        = mld_pkg::CMD_STATUS;
            end
            w_cmd.frame_done = 1'b1;
            n_col    = '0;
            n_line   = '0;
            n_route  = mld_pkg::ROUTE_UNDECIDED;
            n_bright = '0;
            n_dark   = '0;
            n_err    = 1'b0;
        end
    end

    // no prefix write while the back end still replays the previous prefix
    assign o_stall = i_full || (r_replay_busy && w_pref_wr);
    assign w_fire  = i_valid && !o_stall;

    assign o_push      = w_fire && w_push;
    assign o_cmd       = w_cmd;
    assign o_ram_we    = w_fire && w_pref_wr;
    assign o_ram_addr  = AW'(w_col);
    assign o_ram_wdata = i_data.pixel_in;

    always_comb begin
        n_replay_busy = r_replay_busy;
        if (i_replay_done) begin
            n_replay_busy = 1'b0;
        end
        if (o_push && w_cmd.kind == mld_pkg::CMD_REPLAY) begin
            n_replay_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_line        <= '0;
            r_route       <= mld_pkg::ROUTE_UNDECIDED;
            r_bright      <= '0;
            r_dark        <= '0;
            r_err         <= 1'b0;
            r_replay_busy <= 1'b0;
        end else begin
            r_replay_busy <= n_replay_busy;
            if (w_fire) begin
                r_col    <= n_col;
                r_line   <= n_line;
                r_route  <= n_route;
                r_bright <= n_bright;
                r_dark   <= n_dark;
                r_err    <= n_err;
            end
        end
    end

endmodule

// ===== hw/rtl/mld_queue.sv =====
// Command queue between the front end and the back end.
module mld_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mld_pkg::t_cmd i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output mld_pkg::t_cmd o_pop_data,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    mld_pkg::t_cmd r_entry [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_count, n_count;

    assign o_full     = (r_count == NW'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + PW'(1));
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + PW'(1));
        end
        if (i_push && !i_pop) begin
            n_count = NW'(r_count + NW'(1));
        end else if (i_pop && !i_push) begin
            n_count = NW'(r_count - NW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/mld_back.sv =====
// Back end: executes queued commands, replays the prefix, drives the result register.
module mld_back #(
    parameter int PREFIX_DEPTH = 63
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  mld_pkg::t_cmd                    i_cmd,
    output logic                             o_pop,
    input  logic [mld_pkg::PIX_W-1:0]        i_ram_rdata,
    output logic [((PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1)-1:0] o_ram_raddr,
    output logic                             o_replay_done,
    output logic                             o_valid,
    output mld_pkg::t_pix_out                o_data,
    input  logic                             i_stall
);

    localparam int AW  = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
    localparam int MCW = mld_pkg::MC_W;

    mld_pkg::t_back_state r_state, n_state;
    mld_pkg::t_cmd        r_cmd, n_cmd;
    logic [AW-1:0]        r_idx, n_idx;
    logic                 r_out_valid;
    mld_pkg::t_pix_out    r_out;

    logic                 w_out_free;
    logic                 w_last_idx;
    logic                 w_load;
    mld_pkg::t_pix_out    w_load_data;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_last_idx = (MCW'(r_idx) + MCW'(1)) == r_cmd.rep_len;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mld_pkg::BK_CMD: begin
                if (!i_empty && w_out_free && i_cmd.kind == mld_pkg::CMD_REPLAY) begin
                    n_state = mld_pkg::BK_REPLAY;
                end
            end
            mld_pkg::BK_REPLAY: begin
                if (w_out_free && w_last_idx) begin
                    n_state = mld_pkg::BK_MARK;
                end
            end
            mld_pkg::BK_MARK: begin
                if (w_out_free) begin
                    n_state = mld_pkg::BK_CMD;
                end
            end
            default: n_state = mld_pkg::BK_CMD;
        endcase
    end

    always_comb begin
        o_pop         = 1'b0;
        o_replay_done = 1'b0;
        w_load        = 1'b0;
        w_load_data   = '0;
        n_cmd         = r_cmd;
        n_idx         = r_idx;
        case (r_state)
            mld_pkg::BK_CMD: begin
                if (!i_empty && w_out_free) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    if (i_cmd.kind == mld_pkg::CMD_REPLAY) begin
                        n_idx = '0;
                    end else begin
                        w_load                  = 1'b1;
                        w_load_data.pixel_out   = i_cmd.pixel;
                        w_load_data.pixel_valid = (i_cmd.kind != mld_pkg::CMD_STATUS);
                        w_load_data.to_dark     = i_cmd.to_dark;
                        w_load_data.dest_row    = i_cmd.row;
                        w_load_data.dest_col    = i_cmd.col;
                        w_load_data.row_end     = i_cmd.row_end;
                        w_load_data.frame_done  = i_cmd.frame_done;
                        w_load_data.frame_error = i_cmd.frame_error;
                    end
                end
            end
            mld_pkg::BK_REPLAY: begin
                if (w_out_free) begin
                    w_load                  = 1'b1;
                    w_load_data.pixel_out   = i_ram_rdata;
                    w_load_data.pixel_valid = 1'b1;
                    w_load_data.to_dark     = r_cmd.to_dark;
                    w_load_data.dest_row    = r_cmd.row;
                    w_load_data.dest_col    = mld_pkg::COL_W'(r_idx);
                    w_load_data.frame_error = r_cmd.frame_error;
                    if (!w_last_idx) begin
                        n_idx = AW'(r_idx + AW'(1));
                    end
                end
            end
            mld_pkg::BK_MARK: begin
                if (w_out_free) begin
                    w_load                  = 1'b1;
                    o_replay_done           = 1'b1;
                    w_load_data.pixel_out   = r_cmd.pixel;
                    w_load_data.pixel_valid = 1'b1;
                    w_load_data.to_dark     = r_cmd.to_dark;
                    w_load_data.dest_row    = r_cmd.row;
                    w_load_data.dest_col    = r_cmd.col;
                    w_load_data.row_end     = r_cmd.row_end;
                    w_load_data.frame_done  = r_cmd.frame_done;
                    w_load_data.frame_error = r_cmd.frame_error;
                end
            end
            default: ;
        endcase
    end

    // read data always holds the entry at the current r_idx, since the RAM is addressed with the next index
    assign o_ram_raddr = n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mld_pkg::BK_CMD;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (w_load) begin
            r_out <= w_load_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== hw/rtl/marked_line_demultiplexer.sv =====
// Top level of the marked line demultiplexer.
//
// Input channel (i_valid, i_data, o_stall): one 8-bit pixel per transfer in raster
// order, frame_start on the first pixel of a frame. Output channel (o_valid, o_data,
// i_stall): routed pixels tagged with bright/dark image, row and column, plus a
// status-only result (pixel_valid low) when the last pixel of a frame routed nothing.
// Configuration (i_cfg_valid, i_cfg_index, i_cfg_data, o_cfg_ready) is always ready;
// write it only while the block is idle.
// A pixel past the marker column passes through the command queue and the output
// register. The marker pixel of a routed line is preceded by the replay of the
// marker_col prefix pixels: the back end pops the replay command, reads the prefix
// RAM in its replay state and then emits the marker in its mark state.
// The output register takes one result per cycle while i_stall is low and commands
// are waiting; popping a replay command loads none (one prefix RAM read turnaround).
// The front end takes one pixel per cycle while the command queue has room, and
// holds the first prefix pixel of a line until the previous replay is done.
// Reset restores the register defaults and empties the queue and output register;
// the prefix RAM is not cleared. A stalled result holds, and the front end keeps
// accepting until QUEUE_DEPTH commands are waiting.
module marked_line_demultiplexer #(
    parameter int MAX_WIDTH    = 8192,
    parameter int MAX_HEIGHT   = 8192,
    parameter int PREFIX_DEPTH = 63,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mld_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  mld_pkg::t_pix_in               i_data,
    output logic                           o_stall,
    output logic                           o_valid,
    output mld_pkg::t_pix_out              o_data,
    input  logic                           i_stall
);

    localparam int AW = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;

    logic                        w_push;
    mld_pkg::t_cmd               w_push_cmd;
    logic                        w_full;
    logic                        w_pop;
    mld_pkg::t_cmd               w_pop_cmd;
    logic                        w_empty;
    logic                        w_ram_we;
    logic [AW-1:0]               w_ram_waddr;
    logic [mld_pkg::PIX_W-1:0]   w_ram_wdata;
    logic [AW-1:0]               w_ram_raddr;
    logic [mld_pkg::PIX_W-1:0]   w_ram_rdata;
    logic                        w_replay_done;

    mld_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .PREFIX_DEPTH (PREFIX_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_data        (i_data),
        .o_stall       (o_stall),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd),
        .i_full        (w_full),
        .o_ram_we      (w_ram_we),
        .o_ram_addr    (w_ram_waddr),
        .o_ram_wdata   (w_ram_wdata),
        .i_replay_done (w_replay_done)
    );

    mld_ram #(
        .WIDTH (mld_pkg::PIX_W),
        .DEPTH (PREFIX_DEPTH)
    ) u_prefix_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_addr (w_ram_raddr),
        .o_rd_data (w_ram_rdata)
    );

    mld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_cmd),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_cmd),
        .o_empty     (w_empty)
    );

    mld_back #(
        .PREFIX_DEPTH (PREFIX_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_cmd         (w_pop_cmd),
        .o_pop         (w_pop),
        .i_ram_rdata   (w_ram_rdata),
        .o_ram_raddr   (w_ram_raddr),
        .o_replay_done (w_replay_done),
        .o_valid       (o_valid),
        .o_data        (o_data),
        .i_stall       (i_stall)
    );

endmodule

// ===== hw/rtl/mld_checker.sv =====
// Port-level checks of the marked line demultiplexer, bound to the top level.
`include "assert_macros.svh"

module mld_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input mld_pkg::t_pix_out o_data,
    input logic              i_stall
);

    logic w_stalled;
    logic w_status;
    logic w_no_payload;

    assign w_stalled    = o_valid && i_stall;
    assign w_status     = o_valid && !o_data.pixel_valid;
    assign w_no_payload = (o_data.pixel_out == '0) && (o_data.dest_col == '0) &&
                          (o_data.dest_row == '0) && !o_data.row_end && !o_data.to_dark;

    // a stalled result stays put
    `MLD_ASSERT_NXT(a_hold, i_clk, i_rst_n, w_stalled, o_valid && $stable(o_data), "result moved")

    // a status-only result exists only to mark the end of a frame
    `MLD_ASSERT_IMP(a_done, i_clk, i_rst_n, w_status, o_data.frame_done, "status without done")

    // a status-only result carries no routing information
    `MLD_ASSERT_IMP(a_clean, i_clk, i_rst_n, w_status, w_no_payload, "status result with payload")

    // nothing is presented right after reset
    `MLD_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, !o_valid, "result valid after reset")

endmodule

bind marked_line_demultiplexer mld_checker u_mld_checker (.*);

// ===== sim/marked_line_demultiplexer_tb.sv =====
// Self-checking testbench: directed table plus random frames against a line-routing predictor.
module marked_line_demultiplexer_tb;

    localparam int MAX_W         = 8192;
    localparam int MAX_H         = 8192;
    localparam int PREFIX_D      = 63;
    localparam int DRAIN_WAIT    = 100;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PIXELS = 350;

    typedef enum logic {
        STEP_PIXEL,
        STEP_WRITE
    } t_step_kind;

    typedef struct {
        t_step_kind                     kind;
        logic [mld_pkg::CFG_IDX_W-1:0]  idx;
        logic [mld_pkg::CFG_DATA_W-1:0] val;
        mld_pkg::t_pix_in               px;
        bit                             typed;
        mld_pkg::t_pix_out              want;
    } t_step;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic [mld_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mld_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    mld_pkg::t_pix_in               i_data = '0;
    logic                           i_stall = 1'b0;
    logic                           o_cfg_ready;
    logic                           o_stall;
    logic                           o_valid;
    mld_pkg::t_pix_out              o_data;

    // predictor copy of the registers and the line state
    logic [mld_pkg::CFG_DATA_W-1:0] cfg_row_width;
    logic [mld_pkg::CFG_DATA_W-1:0] cfg_frame_height;
    logic [mld_pkg::MC_W-1:0]       cfg_marker_col;
    logic [mld_pkg::PIX_W-1:0]      cfg_bright;
    logic [mld_pkg::PIX_W-1:0]      cfg_dark;
    int unsigned                    col_cnt;
    int unsigned                    line_cnt;
    int unsigned                    bright_rows;
    int unsigned                    dark_rows;
    mld_pkg::t_route                line_route;
    bit                             frame_err;
    logic [mld_pkg::PIX_W-1:0]      prefix_px [PREFIX_D];

    mld_pkg::t_pix_out predicted_px [$];
    mld_pkg::t_pix_out head_px;
    int                fail_count = 0;
    int unsigned       cycle_cnt = 0;
    int unsigned       burst_left = 0;

    marked_line_demultiplexer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_frame();
        col_cnt = 0;
        line_cnt = 0;
        line_route = mld_pkg::ROUTE_UNDECIDED;
        bright_rows = 0;
        dark_rows = 0;
        frame_err = 1'b0;
    endfunction

    function automatic mld_pkg::t_pix_out routed_px(logic [mld_pkg::PIX_W-1:0] pix,
                                                    int unsigned col, bit rend);
        mld_pkg::t_pix_out r;
        r = '0;
        r.pixel_out = pix;
        r.pixel_valid = 1'b1;
        r.to_dark = (line_route == mld_pkg::ROUTE_DARK);
        r.dest_row = (line_route == mld_pkg::ROUTE_DARK) ?
                     dark_rows[mld_pkg::ROW_W-1:0] : bright_rows[mld_pkg::ROW_W-1:0];
        r.dest_col = col[mld_pkg::COL_W-1:0];
        r.row_end = rend;
        return r;
    endfunction

    // Advances the line state by one pixel, queues its results, returns how many.
    function automatic int demux_pixel(mld_pkg::t_pix_in px);
        mld_pkg::t_pix_out res [$];
        int unsigned       w;
        int unsigned       h;
        int unsigned       half;
        int unsigned       mc;
        int unsigned       c;
        bit                last;
        if (px.frame_start) clear_frame();
        w = cfg_row_width;
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        h = cfg_frame_height;
        if (h < 2) h = 2;
        if (h > MAX_H) h = MAX_H;
        half = h / 2;
        mc = cfg_marker_col;
        if (mc > PREFIX_D) mc = PREFIX_D;
        c = col_cnt;
        last = (c + 1 >= w);
        if (line_route == mld_pkg::ROUTE_UNDECIDED) begin
            if (c < mc) begin
                prefix_px[c] = px.pixel_in;
            end else if (c == mc) begin
                // bright is tested first, so equal codes route bright
                if (px.pixel_in == cfg_bright && bright_rows < half)
                    line_route = mld_pkg::ROUTE_BRIGHT;
                else if (px.pixel_in == cfg_bright)
                    line_route = mld_pkg::ROUTE_DROP;
                else if (px.pixel_in == cfg_dark && dark_rows < half)
                    line_route = mld_pkg::ROUTE_DARK;
                else
                    line_route = mld_pkg::ROUTE_DROP;
                if (line_route == mld_pkg::ROUTE_DROP) begin
                    frame_err = 1'b1;
                end else begin
                    for (int i = 0; i < mc; i++)
                        res.push_back(routed_px(prefix_px[i], i, 1'b0));
                    res.push_back(routed_px(px.pixel_in, c, last));
                end
            end else begin
                // marker column passed without a decision
                line_route = mld_pkg::ROUTE_DROP;
                frame_err = 1'b1;
            end
        end else if (line_route != mld_pkg::ROUTE_DROP) begin
            res.push_back(routed_px(px.pixel_in, c, last));
        end
        if (last) begin
            if (line_route == mld_pkg::ROUTE_UNDECIDED)
                frame_err = 1'b1;
            else if (line_route == mld_pkg::ROUTE_BRIGHT)
                bright_rows++;
            else if (line_route == mld_pkg::ROUTE_DARK)
                dark_rows++;
            line_route = mld_pkg::ROUTE_UNDECIDED;
            col_cnt = 0;
            line_cnt++;
        end else begin
            col_cnt = c + 1;
        end
        foreach (res[k]) res[k].frame_error = frame_err;
        if (last && line_cnt >= h) begin
            if (res.size() == 0) begin
                res.push_back(mld_pkg::t_pix_out'('0));
                res[0].frame_error = frame_err;
            end
            res[res.size() - 1].frame_done = 1'b1;
            clear_frame();
        end
        foreach (res[k]) predicted_px.push_back(res[k]);
        return res.size();
    endfunction

    // pixel results at origin end their line when the width is one
    function automatic mld_pkg::t_pix_out origin_res(logic [mld_pkg::PIX_W-1:0] pix, bit valid,
                                                     bit dark, bit done, bit err);
        mld_pkg::t_pix_out r;
        r = '0;
        r.pixel_out = pix;
        r.pixel_valid = valid;
        r.to_dark = dark;
        r.row_end = valid;
        r.frame_done = done;
        r.frame_error = err;
        return r;
    endfunction

    function automatic t_step wr_step(logic [mld_pkg::CFG_IDX_W-1:0] idx,
                                      logic [mld_pkg::CFG_DATA_W-1:0] val);
        t_step s;
        s.kind = STEP_WRITE;
        s.idx = idx;
        s.val = val;
        s.px = '0;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic t_step px_step(logic [mld_pkg::PIX_W-1:0] pix, logic fs,
                                      bit typed = 1'b0, mld_pkg::t_pix_out want = '0);
        t_step s;
        s.kind = STEP_PIXEL;
        s.idx = '0;
        s.val = '0;
        s.px.pixel_in = pix;
        s.px.frame_start = fs;
        s.typed = typed;
        s.want = want;
        return s;
    endfunction

    // Called and returning just after a falling edge.
    task automatic send_pixel(mld_pkg::t_pix_in px, output int n_new);
        int unsigned gap;
        i_cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data <= px;
        do @(posedge i_clk); while (o_stall);
        n_new = demux_pixel(px);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [mld_pkg::CFG_IDX_W-1:0] idx,
                             logic [mld_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mld_pkg::CFG_ROW_WIDTH:    cfg_row_width = val;
            mld_pkg::CFG_FRAME_HEIGHT: cfg_frame_height = val;
            mld_pkg::CFG_MARKER_COL:   cfg_marker_col = val[mld_pkg::MC_W-1:0];
            mld_pkg::CFG_BRIGHT_CODE:  cfg_bright = val[mld_pkg::PIX_W-1:0];
            mld_pkg::CFG_DARK_CODE:    cfg_dark = val[mld_pkg::PIX_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Dropped lines give no result, so wait out the pipeline after the last one.
    task automatic settle();
        i_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (predicted_px.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic random_phase(bit deep, output int unsigned n_px);
        int unsigned               w;
        int unsigned               w_eff;
        int unsigned               h;
        int unsigned               mc;
        int unsigned               budget;
        int unsigned               col_now;
        int unsigned               pick;
        logic [mld_pkg::PIX_W-1:0] bright;
        logic [mld_pkg::PIX_W-1:0] dark;
        mld_pkg::t_pix_in          px;
        int                        n_new;
        settle();
        if (deep) begin
            w = $urandom_range(64, 72);
            h = $urandom_range(2, 3);
        end else begin
            case ($urandom_range(0, 9))
                0:       w = 0;
                1:       w = 1;
                7:       w = $urandom_range(64, 72);
                8:       w = $urandom_range(0, 1) ? 16383 : 8192;
                9:       w = $urandom_range(11, 30);
                default: w = $urandom_range(2, 10);
            endcase
            case ($urandom_range(0, 7))
                0:       h = $urandom_range(0, 1);
                1:       h = 16383;
                2:       h = $urandom_range(10, 40);
                default: h = $urandom_range(2, 9);
            endcase
        end
        w_eff = (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
        if (deep || (w_eff >= 64 && $urandom_range(0, 1)))
            mc = 63;
        else if ($urandom_range(0, 9) == 0)
            mc = $urandom_range(0, 63);
        else
            mc = $urandom_range(0, (w_eff > 11) ? 10 : w_eff - 1);
        bright = mld_pkg::PIX_W'($urandom_range(0, 255));
        dark = ($urandom_range(0, 9) == 0) ? bright : mld_pkg::PIX_W'($urandom_range(0, 255));
        write_reg(mld_pkg::CFG_ROW_WIDTH, w[mld_pkg::CFG_DATA_W-1:0]);
        write_reg(mld_pkg::CFG_FRAME_HEIGHT, h[mld_pkg::CFG_DATA_W-1:0]);
        write_reg(mld_pkg::CFG_MARKER_COL, mc[mld_pkg::CFG_DATA_W-1:0]);
        write_reg(mld_pkg::CFG_BRIGHT_CODE, mld_pkg::CFG_DATA_W'(bright));
        write_reg(mld_pkg::CFG_DARK_CODE, mld_pkg::CFG_DATA_W'(dark));
        budget = (w_eff >= 64 && w_eff < 100) ? 2 * w_eff + 4 : $urandom_range(15, 50);
        repeat (budget) begin
            if (col_cnt == 0 && line_cnt == 0)
                px.frame_start = ($urandom_range(0, 9) != 0);
            else
                px.frame_start = ($urandom_range(0, 49) == 0);
            col_now = px.frame_start ? 0 : col_cnt;
            pick = $urandom_range(0, 19);
            // mostly a valid marker where the line expects one, sometimes junk
            if (col_now == mc && pick < 18 &&
                (px.frame_start || line_route == mld_pkg::ROUTE_UNDECIDED))
                px.pixel_in = (pick < 9) ? bright : dark;
            else
                px.pixel_in = mld_pkg::PIX_W'($urandom_range(0, 255));
            send_pixel(px, n_new);
        end
        n_px = budget;
    endtask

    initial begin : stall_pattern
        int unsigned run;
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 12);
            repeat (run) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            run = $urandom_range(1, 8);
            repeat (run) begin
                @(negedge i_clk);
                i_stall <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_px.size() == 0) begin
                $error("result with nothing expected: %p", o_data);
                fail_count++;
            end else begin
                head_px = predicted_px.pop_front();
                if (o_data.pixel_out !== head_px.pixel_out) begin
                    $error("pixel_out: expected %0d, got %0d",
                           head_px.pixel_out, o_data.pixel_out);
                    fail_count++;
                end
                if (o_data.pixel_valid !== head_px.pixel_valid) begin
                    $error("pixel_valid: expected %0d, got %0d",
                           head_px.pixel_valid, o_data.pixel_valid);
                    fail_count++;
                end
                if (o_data.to_dark !== head_px.to_dark) begin
                    $error("to_dark: expected %0d, got %0d", head_px.to_dark, o_data.to_dark);
                    fail_count++;
                end
                if (o_data.dest_row !== head_px.dest_row) begin
                    $error("dest_row: expected %0d, got %0d", head_px.dest_row, o_data.dest_row);
                    fail_count++;
                end
                if (o_data.dest_col !== head_px.dest_col) begin
                    $error("dest_col: expected %0d, got %0d", head_px.dest_col, o_data.dest_col);
                    fail_count++;
                end
                if (o_data.row_end !== head_px.row_end) begin
                    $error("row_end: expected %0d, got %0d", head_px.row_end, o_data.row_end);
                    fail_count++;
                end
                if (o_data.frame_done !== head_px.frame_done) begin
                    $error("frame_done: expected %0d, got %0d",
                           head_px.frame_done, o_data.frame_done);
                    fail_count++;
                end
                if (o_data.frame_error !== head_px.frame_error) begin
                    $error("frame_error: expected %0d, got %0d",
                           head_px.frame_error, o_data.frame_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("marked_line_demultiplexer_tb: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_step       script [$];
        int          n_new;
        int unsigned n_px;
        int unsigned sent;
        int unsigned phase;
        bit          prev_write;
        cfg_row_width = mld_pkg::RST_ROW_WIDTH;
        cfg_frame_height = mld_pkg::RST_FRAME_HEIGHT;
        cfg_marker_col = mld_pkg::RST_MARKER_COL;
        cfg_bright = mld_pkg::RST_BRIGHT_CODE;
        cfg_dark = mld_pkg::RST_DARK_CODE;
        clear_frame();

        // width 0 and height 1 saturate: one-pixel lines, two lines per frame
        script.push_back(wr_step(mld_pkg::CFG_ROW_WIDTH, 14'd0));
        script.push_back(wr_step(mld_pkg::CFG_FRAME_HEIGHT, 14'd1));
        script.push_back(wr_step(mld_pkg::CFG_MARKER_COL, 14'd0));
        script.push_back(wr_step(mld_pkg::CFG_BRIGHT_CODE, 14'd255));
        script.push_back(wr_step(mld_pkg::CFG_DARK_CODE, 14'd0));
        script.push_back(px_step(8'd255, 1'b1, 1'b1, origin_res(8'd255, 1'b1, 1'b0, 1'b0, 1'b0)));
        script.push_back(px_step(8'd0, 1'b0, 1'b1, origin_res(8'd0, 1'b1, 1'b1, 1'b1, 1'b0)));
        // unknown marker drops the line, the error shows on the frame's last result
        script.push_back(px_step(8'd7, 1'b0));
        script.push_back(px_step(8'd255, 1'b0, 1'b1, origin_res(8'd255, 1'b1, 1'b0, 1'b1, 1'b1)));
        // bright image full: dropped, so the frame end comes as a status result
        script.push_back(px_step(8'd255, 1'b1, 1'b1, origin_res(8'd255, 1'b1, 1'b0, 1'b0, 1'b0)));
        script.push_back(px_step(8'd255, 1'b0, 1'b1, origin_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b1)));
        script.push_back(wr_step(mld_pkg::CFG_DARK_CODE, 14'd255));
        script.push_back(px_step(8'd255, 1'b1, 1'b1, origin_res(8'd255, 1'b1, 1'b0, 1'b0, 1'b0)));
        script.push_back(px_step(8'd255, 1'b0, 1'b1, origin_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b1)));
        // oversized width and height, then the line is narrowed under way
        script.push_back(wr_step(mld_pkg::CFG_ROW_WIDTH, 14'd16383));
        script.push_back(wr_step(mld_pkg::CFG_FRAME_HEIGHT, 14'd16383));
        script.push_back(wr_step(mld_pkg::CFG_MARKER_COL, 14'd2));
        script.push_back(wr_step(mld_pkg::CFG_BRIGHT_CODE, 14'd64));
        script.push_back(wr_step(mld_pkg::CFG_DARK_CODE, 14'd32));
        script.push_back(px_step(8'd1, 1'b1));
        script.push_back(px_step(8'd2, 1'b0));
        script.push_back(px_step(8'd32, 1'b0));
        script.push_back(px_step(8'd170, 1'b0));
        script.push_back(wr_step(mld_pkg::CFG_ROW_WIDTH, 14'd3));
        script.push_back(px_step(8'd85, 1'b0));
        // deepest marker is never reached in a 3-pixel line
        script.push_back(wr_step(mld_pkg::CFG_MARKER_COL, 14'd63));
        script.push_back(px_step(8'd9, 1'b0));
        script.push_back(px_step(8'd8, 1'b0));
        script.push_back(px_step(8'd7, 1'b0));
        script.push_back(px_step(8'd5, 1'b0));
        // marker column moved behind the current column
        script.push_back(wr_step(mld_pkg::CFG_MARKER_COL, 14'd0));
        script.push_back(px_step(8'd6, 1'b0));
        script.push_back(px_step(8'd64, 1'b0));
        script.push_back(px_step(8'd64, 1'b0));
        script.push_back(px_step(8'd0, 1'b0));
        script.push_back(px_step(8'd255, 1'b0));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        prev_write = 1'b0;
        foreach (script[s]) begin
            if (script[s].kind == STEP_WRITE) begin
                if (!prev_write) settle();
                write_reg(script[s].idx, script[s].val);
            end else begin
                send_pixel(script[s].px, n_new);
                if (script[s].typed) begin
                    if (n_new != 1) begin
                        $error("directed step %0d: one result in table, %0d predicted", s, n_new);
                        fail_count++;
                    end else begin
                        predicted_px[predicted_px.size() - 1] = script[s].want;
                    end
                end
            end
            prev_write = (script[s].kind == STEP_WRITE);
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            random_phase(phase == 0, n_px);
            sent += n_px;
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("marked_line_demultiplexer_tb: clean");
        else
            $display("marked_line_demultiplexer_tb: errors");
        $finish;
    end

endmodule
